FILE: hdl/wildcard_byte_signature_scanner_assert.svh
// Assertion macros for the wildcard byte signature scanner.
// Needs a clk and an rst in the scope of each use; no other dependencies.
`ifndef WILDCARD_BYTE_SIGNATURE_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_SIGNATURE_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WBSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WBSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WBSS_ASSERT_SAME(label, ante, cons, msg)
`define WBSS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hdl/wbss_pkg.sv
// Shared types, constants and helpers for the wildcard byte signature scanner.
// No dependencies.
`default_nettype none

package wbss_pkg;

  localparam int PAT_BYTES                 = 16;
  localparam int DEFAULT_MAX_PATTERN_BYTES = 16;
  localparam int CFG_DATA_W                = 64;
  localparam int CFG_INDEX_W               = 3;
  localparam int LEN_W                     = 5;
  localparam int SEC_W                     = 7;
  localparam int OFFSET_W                  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_EXEC_ONLY    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          length;     // already clamped to the lane count
    logic                      exec_only;
  } cfg_t;

  // compare lanes actually in use for a given maximum pattern size
  function automatic int lanes_of(input int max_bytes);
    return (max_bytes < PAT_BYTES) ? max_bytes : PAT_BYTES;
  endfunction

  // stored history bytes; at least one so the vector is never empty
  function automatic int window_of(input int max_bytes);
    return (lanes_of(max_bytes) > 1) ? lanes_of(max_bytes) - 1 : 1;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/wildcard_byte_signature_scanner.sv
// Wildcard byte signature scanner: one input word per cycle, one result per image.
// Full throughput: an input register, a single compare stage against a shift-register
// window, and a result register; a new word enters every clock unless a result word
// is held back by out_ready. The result register is loaded as its input word leaves the input register.
// After a hit no further result appears until image_end, which reports not-found only
// when nothing was hit, then rearms. Configuration is taken one register per write.
// Depends on wbss_pkg, wbss_cfg, wbss_match and the assertion macro header.
`default_nettype none
`include "wildcard_byte_signature_scanner_assert.svh"

module wildcard_byte_signature_scanner #(
  parameter int MAX_PATTERN_BYTES = wbss_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [wbss_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [wbss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        data_byte,
  input  wire logic                              section_start,
  input  wire logic [wbss_pkg::SEC_W-1:0]        section_number,
  input  wire logic                              section_readable,
  input  wire logic                              section_executable,
  input  wire logic                              image_end,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   found,
  output logic [wbss_pkg::SEC_W-1:0]             hit_section,
  output logic [wbss_pkg::OFFSET_W-1:0]          hit_offset
);
  import wbss_pkg::*;

  localparam int WIN      = window_of(MAX_PATTERN_BYTES);
  localparam int WIN_BITS = WIN * 8;

  cfg_t cfg;

  // input register
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_start;
  logic [SEC_W-1:0] s1_sec;
  logic             s1_rd;
  logic             s1_ex;
  logic             s1_end;

  // scan state
  logic [WIN-1:0][7:0]   window;
  logic [OFFSET_W-1:0]   count;
  logic                  scan_done;

  logic [WIN-1:0][7:0]   win_eff;
  logic [OFFSET_W-1:0]   count_base;
  logic [OFFSET_W-1:0]   count_next;
  logic                  match;
  logic                  hit;
  logic                  produce;
  logic                  advance;

  wbss_cfg #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign win_eff    = s1_start ? '0 : window;
  assign count_base = s1_start ? '0 : count;
  assign count_next = (&count_base) ? count_base : count_base + OFFSET_W'(1);

  wbss_match #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_match (
    .cur_byte (s1_byte),
    .window   (win_eff),
    .cfg      (cfg),
    .match    (match)
  );

  assign hit = !scan_done && (cfg.length != '0) && s1_rd && !(cfg.exec_only && !s1_ex) &&
               (count_next >= OFFSET_W'(cfg.length)) && match;
  assign produce = hit || (s1_end && !scan_done);

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_start <= section_start;
      s1_sec   <= section_number;
      s1_rd    <= section_readable;
      s1_ex    <= section_executable;
      s1_end   <= image_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      count     <= '0;
      scan_done <= 1'b0;
    end else if (advance) begin
      if (s1_end) begin
        // rearm for the next image
        window    <= '0;
        count     <= '0;
        scan_done <= 1'b0;
      end else begin
        // newest byte into slot 0, oldest falls off the top
        window    <= WIN_BITS'({win_eff, s1_byte});
        count     <= count_next;
        scan_done <= scan_done || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      found       <= hit;
      hit_section <= hit ? s1_sec : '0;
      hit_offset  <= hit ? count_next - OFFSET_W'(cfg.length) : '0;
    end
  end

  `WBSS_ASSERT_SAME(a_notfound_zero, out_valid && !found, hit_section == '0 && hit_offset == '0, "not-found word carries a nonzero section or offset")
  `WBSS_ASSERT_SAME(a_done_blocks_hit, scan_done, !hit, "hit raised after the image was already reported")
  `WBSS_ASSERT_NEXT(a_hit_sets_done, advance && hit && !s1_end, scan_done, "scan_done not set after a hit")
  `WBSS_ASSERT_NEXT(a_end_rearms, advance && s1_end, count == '0 && !scan_done, "image end did not rearm the scan")

endmodule

`default_nettype wire

FILE: hdl/wbss_cfg.sv
// Configuration register file: pattern, care mask, length and section filter.
// Depends on wbss_pkg.
`default_nettype none

module wbss_cfg #(
  parameter int MAX_PATTERN_BYTES = wbss_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [wbss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output wbss_pkg::cfg_t                     cfg
);
  import wbss_pkg::*;

  localparam int LANES = lanes_of(MAX_PATTERN_BYTES);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LANES);

  logic [LEN_W-1:0] len_clamped;

  assign len_clamped = (cfg_wdata[LEN_W-1:0] > LEN_CAP) ? LEN_CAP : cfg_wdata[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  cfg.pattern[7:0]  <= cfg_wdata;
        REG_PATTERN_HIGH: cfg.pattern[15:8] <= cfg_wdata;
        REG_CARE_MASK:    cfg.care          <= cfg_wdata[PAT_BYTES-1:0];
        REG_PATTERN_LEN:  cfg.length        <= len_clamped;
        REG_EXEC_ONLY:    cfg.exec_only     <= cfg_wdata[0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wbss_match.sv
// Parallel masked compare of the window ending at the current byte.
// Depends on wbss_pkg.
`default_nettype none

module wbss_match #(
  parameter int MAX_PATTERN_BYTES = wbss_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
  input  wire logic [7:0]  cur_byte,
  input  wire logic [wbss_pkg::window_of(MAX_PATTERN_BYTES)-1:0][7:0] window,
  input  wbss_pkg::cfg_t   cfg,
  output logic             match
);
  import wbss_pkg::*;

  localparam int LANES = lanes_of(MAX_PATTERN_BYTES);

  // lane p looks at the byte p places back from the current one
  logic [LANES-1:0][7:0] lane_byte;
  logic [LANES-1:0]      lane_ok;

  assign lane_byte[0] = cur_byte;

  for (genvar p = 1; p < LANES; p++) begin : g_tap
    assign lane_byte[p] = window[p-1];
  end

  for (genvar p = 0; p < LANES; p++) begin : g_lane
    logic [LEN_W-1:0] j;  // pattern byte that lines up with this lane
    assign j = cfg.length - LEN_W'(1) - LEN_W'(p);
    assign lane_ok[p] = (LEN_W'(p) >= cfg.length) || !cfg.care[j[3:0]] ||
                        (lane_byte[p] == cfg.pattern[j[3:0]]);
  end

  assign match = &lane_ok;

endmodule

`default_nettype wire

FILE: test/wildcard_byte_signature_scanner_tb.sv
// Testbench for the wildcard byte signature scanner: streams images of sections
// through the input channel and compares each hit or not-found word with a local model.
// Depends on wbss_pkg and the scanner RTL.
`timescale 1ns / 100ps

module wildcard_byte_signature_scanner_tb;
  import wbss_pkg::*;

  localparam int WIN_DEPTH          = 15;     // earlier bytes kept per section
  localparam int NUM_PHASES         = 12;
  localparam int PHASE_WORDS        = 50;
  localparam int LATENCY_PAUSE      = 8;
  localparam int LONG_HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER_RESULTS = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam int                     REG_SPARE_COUNT = 3;

  typedef struct packed {
    logic [7:0]       data;
    logic             start;
    logic [SEC_W-1:0] section;
    logic             readable;
    logic             executable;
    logic             last;
  } scan_word_t;

  typedef struct packed {
    logic                found;
    logic [SEC_W-1:0]    section;
    logic [OFFSET_W-1:0] offset;
  } scan_hit_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             data_byte = '0;
  logic                   section_start = 1'b0;
  logic [SEC_W-1:0]       section_number = '0;
  logic                   section_readable = 1'b0;
  logic                   section_executable = 1'b0;
  logic                   image_end = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   found;
  logic [SEC_W-1:0]       hit_section;
  logic [OFFSET_W-1:0]    hit_offset;

  wildcard_byte_signature_scanner DUT (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .data_byte          (data_byte),
    .section_start      (section_start),
    .section_number     (section_number),
    .section_readable   (section_readable),
    .section_executable (section_executable),
    .image_end          (image_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .found              (found),
    .hit_section        (hit_section),
    .hit_offset         (hit_offset)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // scanner model: configuration copy and per-section state
  logic [63:0] pat_low_r = '0;
  logic [63:0] pat_high_r = '0;
  logic [15:0] care_r = '0;
  logic [4:0]  len_r = '0;
  logic        exec_only_r = 1'b0;
  logic [7:0]  window_r [WIN_DEPTH];
  logic [31:0] seen_r = '0;
  logic        done_r = 1'b0;

  scan_hit_t  hits_due[$];
  scan_word_t words_pending[$];
  int         words_made = 0;
  int         fail_count = 0;

  function automatic int active_len();
    return (len_r > 5'd16) ? 16 : int'(len_r);
  endfunction

  function automatic logic [7:0] pattern_byte(input int j);
    return (j < 8) ? pat_low_r[8*j +: 8] : pat_high_r[8*(j-8) +: 8];
  endfunction

  function automatic void note_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_PATTERN_LOW:  pat_low_r = d;
      REG_PATTERN_HIGH: pat_high_r = d;
      REG_CARE_MASK:    care_r = d[15:0];
      REG_PATTERN_LEN:  len_r = d[4:0];
      REG_EXEC_ONLY:    exec_only_r = d[0];
      default: ;
    endcase
  endfunction

  function automatic void clear_window();
    foreach (window_r[k]) window_r[k] = '0;
    seen_r = '0;
  endfunction

  function automatic void scan_word(input scan_word_t w);
    int        n;
    bit        hit;
    logic [7:0] b;
    scan_hit_t h;
    n = active_len();
    if (w.start) clear_window();
    if (seen_r != '1) seen_r++;
    hit = !done_r && n > 0 && w.readable && !(exec_only_r && !w.executable) &&
          seen_r >= n;
    if (hit) begin
      for (int j = 0; j < n; j++) begin
        b = (j == n - 1) ? w.data : window_r[n-2-j];
        if (care_r[j] && b != pattern_byte(j)) hit = 0;
      end
    end
    if (hit) begin
      h.found   = 1'b1;
      h.section = w.section;
      h.offset  = seen_r - 32'(n);
      hits_due.insert(hits_due.size(), h);
      done_r = 1'b1;
    end
    for (int k = WIN_DEPTH - 1; k > 0; k--) window_r[k] = window_r[k-1];
    window_r[0] = w.data;
    if (w.last) begin
      if (!done_r) begin
        h = '0;
        hits_due.insert(hits_due.size(), h);
      end
      clear_window();
      done_r = 1'b0;
    end
  endfunction

  function automatic void push_word(input logic [7:0] d, input logic st,
                                    input logic [SEC_W-1:0] sc, input logic rd,
                                    input logic ex, input logic lst);
    scan_word_t w;
    w.data = d;
    w.start = st;
    w.section = sc;
    w.readable = rd;
    w.executable = ex;
    w.last = lst;
    words_pending.insert(words_pending.size(), w);
    words_made++;
  endfunction

  // sender: bursts of random length separated by random gaps
  int         burst_left = 0;
  int         gap_left = 0;
  scan_word_t on_offer;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) scan_word(on_offer);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (words_pending.size() > 0) begin
          on_offer = words_pending.pop_front();
          in_valid           <= 1'b1;
          data_byte          <= on_offer.data;
          section_start      <= on_offer.start;
          section_number     <= on_offer.section;
          section_readable   <= on_offer.readable;
          section_executable <= on_offer.executable;
          image_end          <= on_offer.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall patterns in turn; one long hold-off
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       results_taken = 0;
  bit       long_hold_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_taken >= HOLD_AFTER_RESULTS && in_valid) begin
        // sender still busy, so the pipeline backs up into in_ready
        long_hold_done = 1;
        hold_left = LONG_HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  scan_hit_t hit_want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (hits_due.size() == 0) begin
        $error("result word with nothing expected: found=%0d section=%0d offset=%0d",
               found, hit_section, hit_offset);
        fail_count++;
      end else begin
        hit_want = hits_due.pop_front();
        if (found !== hit_want.found) begin
          $error("found: expected %0d, got %0d", hit_want.found, found);
          fail_count++;
        end
        if (hit_section !== hit_want.section) begin
          $error("hit_section: expected %0d, got %0d", hit_want.section, hit_section);
          fail_count++;
        end
        if (hit_offset !== hit_want.offset) begin
          $error("hit_offset: expected %0d, got %0d", hit_want.offset, hit_offset);
          fail_count++;
        end
      end
    end
  end

  // hold the sender until every expected word is back and the pipe has drained
  task automatic settle();
    while (words_pending.size() != 0 || in_valid || hits_due.size() != 0)
      @(posedge clk);
    repeat (LATENCY_PAUSE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    note_cfg(idx, d);
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic make_image();
    int               n;
    int               nsec;
    int               slen;
    int               pos;
    int               flip;
    bit               broken;
    logic [7:0]       bytes_q[$];
    logic [SEC_W-1:0] sec;
    logic             rd;
    logic             ex;
    logic             st;
    logic             lst;
    n = active_len();
    broken = ($urandom_range(0, 11) == 0);
    nsec = $urandom_range(1, 4);
    for (int s = 0; s < nsec; s++) begin
      slen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      if (n > 8 && $urandom_range(0, 2) == 0) slen = $urandom_range(n, n + 24);
      sec = 7'($urandom_range(0, 95));
      rd = ($urandom_range(0, 5) != 0);
      ex = ($urandom_range(0, 2) != 0);
      bytes_q.delete();
      for (int i = 0; i < slen; i++)
        bytes_q.insert(bytes_q.size(),
                       ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                   : pattern_byte($urandom_range(0, 15)));
      // plant the pattern, now and then with one byte spoilt
      if (n > 0 && slen >= n && $urandom_range(0, 99) < 55) begin
        pos = $urandom_range(0, slen - n);
        for (int j = 0; j < n; j++)
          if (care_r[j]) bytes_q[pos+j] = pattern_byte(j);
        if ($urandom_range(0, 4) == 0) begin
          flip = $urandom_range(0, n - 1);
          bytes_q[pos+flip] = bytes_q[pos+flip] ^ 8'($urandom_range(1, 255));
        end
      end
      for (int i = 0; i < slen; i++) begin
        lst = (s == nsec - 1) && (i == slen - 1);
        if (broken) begin
          st = ($urandom_range(0, 3) == 0);
          push_word(bytes_q[i], st, sec, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), lst);
        end else begin
          st = (i == 0) ? ($urandom_range(0, 29) != 0) : ($urandom_range(0, 39) == 0);
          push_word(bytes_q[i], st, sec, rd ^ ($urandom_range(0, 49) == 0),
                    ex ^ ($urandom_range(0, 49) == 0), lst);
        end
      end
    end
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] care;
    logic [4:0]  plen;
    logic [63:0] junk;
    int          phase_start;

    foreach (window_r[k]) window_r[k] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero length never matches
    push_word(8'h00, 1'b1, 7'd0, 1'b1, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 7'd0, 1'b1, 1'b1, 1'b1);
    settle();

    // pattern 00 ?? A5 FF, byte 1 a wildcard
    cfg_write(REG_PATTERN_LOW, 64'h0000_0000_FFA5_FF00);
    cfg_write(REG_PATTERN_HIGH, '1);
    cfg_write(REG_CARE_MASK, 64'hFFFD);
    cfg_write(REG_PATTERN_LEN, 64'd4);
    cfg_write(REG_EXEC_ONLY, 64'd0);
    cfg_done();

    // hit at offset 1, later match in the same image suppressed
    push_word(8'hFF, 1'b1, 7'd95, 1'b1, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 7'd95, 1'b1, 1'b1, 1'b0);
    push_word(8'h12, 1'b0, 7'd95, 1'b1, 1'b1, 1'b0);
    push_word(8'hA5, 1'b0, 7'd95, 1'b1, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 7'd95, 1'b1, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 7'd95, 1'b1, 1'b1, 1'b0);
    push_word(8'h77, 1'b0, 7'd95, 1'b1, 1'b1, 1'b0);
    push_word(8'hA5, 1'b0, 7'd95, 1'b1, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 7'd95, 1'b1, 1'b1, 1'b1);
    // unreadable section: not found
    push_word(8'h00, 1'b1, 7'd0, 1'b0, 1'b1, 1'b0);
    push_word(8'h11, 1'b0, 7'd0, 1'b0, 1'b1, 1'b0);
    push_word(8'hA5, 1'b0, 7'd0, 1'b0, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 7'd0, 1'b0, 1'b1, 1'b1);
    // match completes on the image's last byte
    push_word(8'h00, 1'b1, 7'd64, 1'b1, 1'b1, 1'b0);
    push_word(8'h33, 1'b0, 7'd64, 1'b1, 1'b1, 1'b0);
    push_word(8'hA5, 1'b0, 7'd64, 1'b1, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 7'd64, 1'b1, 1'b1, 1'b1);
    settle();

    // executable-only: first section skipped, second one hits
    cfg_write(REG_EXEC_ONLY, 64'd1);
    cfg_done();
    push_word(8'h00, 1'b1, 7'd1, 1'b1, 1'b0, 1'b0);
    push_word(8'h01, 1'b0, 7'd1, 1'b1, 1'b0, 1'b0);
    push_word(8'hA5, 1'b0, 7'd1, 1'b1, 1'b0, 1'b0);
    push_word(8'hFF, 1'b0, 7'd1, 1'b1, 1'b0, 1'b0);
    push_word(8'h00, 1'b1, 7'd2, 1'b1, 1'b1, 1'b0);
    push_word(8'h02, 1'b0, 7'd2, 1'b1, 1'b1, 1'b0);
    push_word(8'hA5, 1'b0, 7'd2, 1'b1, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 7'd2, 1'b1, 1'b1, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      care = 16'($urandom) | 16'($urandom);
      plen = 5'($urandom_range(1, 16));
      case (p)
        0: begin plen = 5'd16; care = '1; end
        1: plen = 5'($urandom_range(17, 31));   // overlong, clamps to 16
        2: plen = 5'd1;
        3: begin care = '0; plen = 5'($urandom_range(2, 15)); end
        4: begin lo = '0; hi = '0; care = '1; plen = 5'd16; end
        5: begin lo = '1; hi = '1; care = '1; end
        6: plen = 5'd0;
        default: ;
      endcase
      // odd phases put junk above the register width
      junk = (p % 2) ? {$urandom, $urandom} : '0;
      cfg_write(REG_PATTERN_LOW, lo);
      cfg_write(REG_PATTERN_HIGH, hi);
      cfg_write(REG_CARE_MASK, {junk[63:16], care});
      cfg_write(REG_PATTERN_LEN, {junk[63:5], plen});
      cfg_write(REG_EXEC_ONLY, {junk[63:1], 1'($urandom_range(0, 1))});
      cfg_write(REG_SPARE_FIRST + 3'($urandom_range(0, REG_SPARE_COUNT - 1)),
                {$urandom, $urandom});
      cfg_done();
      phase_start = words_made;
      while (words_made - phase_start < PHASE_WORDS) make_image();
    end

    settle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
